FILE: sv/lssc_pkg.sv
// ----------------------------------------------------------------------------
// lssc_pkg
// Shared types and constants for the line sensor steering correction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

  localparam int SENSOR_COUNT = 16;

  // Register map, index = paddr[3:2]
  localparam logic [1:0] REG_GAIN_KP    = 2'd0;
  localparam logic [1:0] REG_ERR_POWER  = 2'd1;
  localparam logic [1:0] REG_CENTER     = 2'd2;
  localparam logic [1:0] REG_WHITE_W    = 2'd3;

  localparam logic [15:0] GAIN_KP_RST   = 16'd100;
  localparam logic [2:0]  ERR_POWER_RST = 3'd1;
  localparam logic [3:0]  CENTER_RST    = 4'd8;
  localparam logic [3:0]  WHITE_W_RST   = 4'd10;

  localparam int CORR_LIMIT  = 180;
  localparam int GAIN_SCALE  = 100;
  // Smallest gain*power product that saturates the correction
  localparam int SAT_PROD    = (CORR_LIMIT + 1) * GAIN_SCALE;
  localparam int PW_W        = $clog2(SAT_PROD + 1);
  localparam int GAIN_W      = 16;
  localparam int MUL_A_W     = GAIN_W;
  localparam int MUL_B_W     = PW_W;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  // x/100 for x < SAT_PROD as (x*RECIP_MULT) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_MULT  = ((2 ** RECIP_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;
  localparam int Q_W         = $clog2(CORR_LIMIT + 1);

  typedef enum logic [1:0] {
    FLAG_NORMAL = 2'd0,
    FLAG_NONE   = 2'd1,
    FLAG_EDGE   = 2'd2,
    FLAG_WHITE  = 2'd3
  } line_flag_t;

  typedef struct packed {
    logic [15:0] gain_kp;
    logic [2:0]  error_power;
    logic [3:0]  center_index;
    logic [3:0]  all_white_width;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] correction;
    line_flag_t        line_flag;
    logic [3:0]        tracked_center;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/lssc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lssc_cfg_regs
// APB-style configuration registers: gain, error power, center, white width.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lssc_pkg::cfg_t     cfg
);
  import lssc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_kp         <= GAIN_KP_RST;
      cfg.error_power     <= ERR_POWER_RST;
      cfg.center_index    <= CENTER_RST;
      cfg.all_white_width <= WHITE_W_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN_KP:   cfg.gain_kp         <= pwdata[15:0];
        REG_ERR_POWER: cfg.error_power     <= pwdata[2:0];
        REG_CENTER:    cfg.center_index    <= pwdata[3:0];
        REG_WHITE_W:   cfg.all_white_width <= pwdata[3:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_KP:   prdata = {16'd0, cfg.gain_kp};
      REG_ERR_POWER: prdata = {29'd0, cfg.error_power};
      REG_CENTER:    prdata = {28'd0, cfg.center_index};
      REG_WHITE_W:   prdata = {28'd0, cfg.all_white_width};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lssc_run_scan.sv
// ----------------------------------------------------------------------------
// lssc_run_scan
// Bit-serial scan of the masked frame, one sensor per cycle, tracking the
// widest run of ones (later run wins a tie).
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_run_scan #(
  parameter int NUM_SENSORS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [NUM_SENSORS-1:0]         seen,
  output logic                                done,
  output logic [$clog2(NUM_SENSORS)-1:0]      best_s,
  output logic [$clog2(NUM_SENSORS)-1:0]      best_e,
  output logic [$clog2(NUM_SENSORS)-1:0]      max_w
);
  localparam int IW = $clog2(NUM_SENSORS);
  localparam logic [IW-1:0] LAST = IW'(NUM_SENSORS - 1);

  logic                   busy;
  logic [IW-1:0]          idx;
  logic [NUM_SENSORS-1:0] sh;
  logic                   in_run;
  logic [IW-1:0]          run_s;
  logic [IW-1:0]          run_e;

  logic          in_run_next;
  logic [IW-1:0] run_s_next;
  logic [IW-1:0] run_e_next;
  logic [IW-1:0] best_s_next;
  logic [IW-1:0] best_e_next;
  logic [IW-1:0] max_w_next;

  always_comb begin
    in_run_next = in_run;
    run_s_next  = run_s;
    run_e_next  = run_e;
    best_s_next = best_s;
    best_e_next = best_e;
    max_w_next  = max_w;
    if (sh[0]) begin
      if (in_run) begin
        run_e_next = idx;
      end else begin
        run_s_next  = idx;
        run_e_next  = idx;
        in_run_next = 1'b1;
      end
    end else if (in_run) begin
      in_run_next = 1'b0;
      if (run_e - run_s >= max_w) begin
        max_w_next  = run_e - run_s;
        best_s_next = run_s;
        best_e_next = run_e;
      end
    end
    // close a run still open at the top end of the bar
    if (idx == LAST && in_run_next) begin
      if (LAST - run_s_next >= max_w_next) begin
        max_w_next  = LAST - run_s_next;
        best_s_next = run_s_next;
        best_e_next = LAST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy & ~start & (idx == LAST);
      if (start) begin
        busy   <= 1'b1;
        idx    <= '0;
        sh     <= seen;
        in_run <= 1'b0;
        run_s  <= '0;
        run_e  <= '0;
        best_s <= '0;
        best_e <= '0;
        max_w  <= '0;
      end else if (busy) begin
        sh     <= sh >> 1;
        idx    <= idx + 1'b1;
        in_run <= in_run_next;
        run_s  <= run_s_next;
        run_e  <= run_e_next;
        best_s <= best_s_next;
        best_e <= best_e_next;
        max_w  <= max_w_next;
        if (idx == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lssc_corr_unit.sv
// ----------------------------------------------------------------------------
// lssc_corr_unit
// Midpoint, flag and correction. One shared multiplier does the power
// steps, the gain product and the divide by 100 (reciprocal multiply).
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_corr_unit #(
  parameter int NUM_SENSORS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lssc_pkg::cfg_t              cfg,
  input  wire logic                        start,
  input  wire logic [$clog2(NUM_SENSORS)-1:0] best_s,
  input  wire logic [$clog2(NUM_SENSORS)-1:0] best_e,
  input  wire logic [$clog2(NUM_SENSORS)-1:0] max_w,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output lssc_pkg::res_t                   res
);
  import lssc_pkg::*;

  localparam int IW = $clog2(NUM_SENSORS);
  localparam int VW = (IW > 4) ? IW : 4;
  localparam logic [IW-1:0] LAST = IW'(NUM_SENSORS - 1);

  typedef enum logic [2:0] {
    C_IDLE,
    C_POW,
    C_GAIN,
    C_RECIP,
    C_DONE
  } cstate_t;

  cstate_t            state;
  logic [PW_W-1:0]    pw;
  logic [VW-1:0]      mag;
  logic               pos;
  logic [2:0]         cnt;
  logic [MUL_P_W-1:0] prod;
  line_flag_t         flag_r;
  logic [3:0]         mid_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic               white;
  logic               at_end;
  logic [VW-1:0]      mid_v;
  logic [VW-1:0]      ctr_v;
  logic [Q_W-1:0]     q;

  assign mid_sum = {1'b0, best_s} + {1'b0, best_e};
  assign mid     = mid_sum[IW:1];
  assign mid_v   = VW'(mid);
  assign ctr_v   = VW'(cfg.center_index);
  assign white   = VW'(max_w) >= VW'(cfg.all_white_width);
  assign at_end  = (best_s == '0) || (best_e == LAST);

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      C_POW: begin
        mul_a = MUL_A_W'(pw);
        mul_b = MUL_B_W'(mag);
      end
      C_GAIN: begin
        mul_a = cfg.gain_kp;
        mul_b = MUL_B_W'(pw);
      end
      C_RECIP: begin
        mul_a = MUL_A_W'(prod[PW_W-1:0]);
        mul_b = MUL_B_W'(RECIP_MULT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign q     = (prod >= MUL_P_W'(SAT_PROD)) ? Q_W'(CORR_LIMIT)
                                              : mul_p[RECIP_SHIFT +: Q_W];
  assign res_valid = (state == C_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (start) begin
            if (mid == '0) begin
              // midpoint zero counts as nothing seen
              res.correction     <= '0;
              res.line_flag      <= FLAG_NONE;
              res.tracked_center <= cfg.center_index;
              state              <= C_DONE;
            end else begin
              pos    <= mid_v > ctr_v;
              mag    <= (mid_v > ctr_v) ? mid_v - ctr_v : ctr_v - mid_v;
              pw     <= PW_W'(1);
              cnt    <= cfg.error_power;
              mid_r  <= 4'(mid);
              flag_r <= white ? FLAG_WHITE : (at_end ? FLAG_EDGE : FLAG_NORMAL);
              state  <= C_POW;
            end
          end
        end
        C_POW: begin
          if (cnt == 3'd0) begin
            state <= C_GAIN;
          end else begin
            // clamp keeps saturation decisions exact
            pw  <= (mul_p >= MUL_P_W'(SAT_PROD)) ? PW_W'(SAT_PROD) : mul_p[PW_W-1:0];
            cnt <= cnt - 3'd1;
          end
        end
        C_GAIN: begin
          prod  <= mul_p;
          state <= C_RECIP;
        end
        C_RECIP: begin
          res.correction     <= pos ? $signed(9'(q)) : -$signed(9'(q));
          res.line_flag      <= flag_r;
          res.tracked_center <= mid_r;
          state              <= C_DONE;
        end
        C_DONE: begin
          if (res_take) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/line_sensor_steering_correction_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_steering_correction_unit
// Masks each frame with the previous one, finds the widest run of lit
// sensors and turns its midpoint offset into a saturated steering correction.
//
//   channel  signals                          direction  item
//   in       in_valid/in_ready, sensor_bits   input      one sensor frame
//   out      out_valid/out_ready, correction, output     one result
//            line_flag, tracked_center
//   cfg      psel/penable/pwrite/paddr/pwdata input      register write
//
// Accept to out_valid: run scan of the masked frame, shared multiplier for
// power steps, gain and divide (skipped for a zero midpoint), then output
// register. One item is in work at a time; in_ready drops on accept and
// returns when the result moves to the output register, so a new item can
// start while that result waits. Synchronous reset clears the previous
// frame and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_steering_correction_unit #(
  parameter int NUM_SENSORS = lssc_pkg::SENSOR_COUNT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [NUM_SENSORS-1:0] sensor_bits,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [8:0]           correction,
  output logic [1:0]                  line_flag,
  output logic [3:0]                  tracked_center,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lssc_pkg::*;

  localparam int IW = $clog2(NUM_SENSORS);

  cfg_t                   cfg;
  res_t                   res;
  logic                   busy;
  logic [NUM_SENSORS-1:0] prev_frame;
  logic                   in_acc;
  logic                   scan_done;
  logic [IW-1:0]          best_s;
  logic [IW-1:0]          best_e;
  logic [IW-1:0]          max_w;
  logic                   res_valid;
  logic                   res_take;

  assign in_ready = ~busy;
  assign in_acc   = in_valid & in_ready;
  assign res_take = res_valid & (~out_valid | out_ready);

  lssc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lssc_run_scan #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .seen   (sensor_bits & prev_frame),
    .done   (scan_done),
    .best_s (best_s),
    .best_e (best_e),
    .max_w  (max_w)
  );

  lssc_corr_unit #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_corr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (scan_done),
    .best_s    (best_s),
    .best_e    (best_e),
    .max_w     (max_w),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      prev_frame <= '0;
    end else begin
      if (in_acc) begin
        busy       <= 1'b1;
        prev_frame <= sensor_bits;
      end else if (res_take) begin
        busy <= 1'b0;
      end
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      correction     <= res.correction;
      line_flag      <= res.line_flag;
      tracked_center <= res.tracked_center;
    end
  end

`ifndef SYNTHESIS
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correction <= 9'sd180) && (correction >= -9'sd180))
    else $error("correction out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_flag == FLAG_NONE) |-> (correction == 9'sd0))
    else $error("nothing-seen result with nonzero correction");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (scan_done || res_valid) |-> busy)
    else $error("scan or result activity while block idle");

  a_take_clear: assert property (@(posedge clk) disable iff (rst)
    res_take |=> !res_valid && !busy)
    else $error("result not retired after handoff");
`endif

endmodule

`default_nettype wire

FILE: tb/line_sensor_steering_correction_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_sensor_steering_correction_unit_tb
// Drives sensor frames through the steering unit under several register
// settings. Each accepted frame is run through a local model of the masking,
// widest-run search and powered, scaled, saturated correction. Every result
// leaving the block is checked against that model in order.
// ----------------------------------------------------------------------------
module line_sensor_steering_correction_unit_tb;
  import lssc_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int SETTLE_CYCLES = 2 * SENSOR_COUNT + 16;
  localparam int HOLD_AFTER    = 300;   // results seen before the long output stall
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_FRAMES  = 240;
  localparam longint POWER_CEIL = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] sensor_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [8:0] correction;
  logic [1:0]  line_flag;
  logic [3:0]  tracked_center;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_sensor_steering_correction_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sensor_bits(sensor_bits),
    .out_valid(out_valid), .out_ready(out_ready), .correction(correction),
    .line_flag(line_flag), .tracked_center(tracked_center),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // model state
  cfg_t        active_cfg = '{GAIN_KP_RST, ERR_POWER_RST, CENTER_RST, WHITE_W_RST};
  logic [15:0] last_frame = '0;

  logic [15:0] frames_to_send [$];
  res_t        predicted_results [$];

  int mismatches = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int settings_used = 1;
  int saturated = 0;
  int flag_seen [4] = '{0, 0, 0, 0};

  // frame generator state
  int          track_pos = 8;
  int          track_w = 4;
  bit          repeat_next = 1'b0;
  logic [15:0] gen_last = '0;

  function automatic res_t predict_steering(logic [15:0] frame, logic [15:0] prior,
                                            cfg_t c);
    logic [15:0] lit;
    int best_lo, best_hi, widest, run_lo, run_hi, mid;
    bit in_run;
    line_flag_t flag;
    longint offset, mag, powered, scaled;
    res_t r;
    lit = frame & prior;
    best_lo = 0; best_hi = 0; widest = 0; run_lo = 0; run_hi = 0;
    in_run = 1'b0;
    // one step past the last sensor closes a run that touches the top end
    for (int i = 0; i <= SENSOR_COUNT; i++) begin
      if (i < SENSOR_COUNT && lit[i]) begin
        if (!in_run) begin
          run_lo = i;
          in_run = 1'b1;
        end
        run_hi = i;
      end else if (in_run) begin
        in_run = 1'b0;
        if (run_hi - run_lo >= widest) begin   // later run wins a tie
          widest = run_hi - run_lo;
          best_lo = run_lo;
          best_hi = run_hi;
        end
      end
    end
    mid = (best_lo + best_hi) / 2;
    if (widest >= c.all_white_width) flag = FLAG_WHITE;
    else if (best_lo == 0 || best_hi == SENSOR_COUNT - 1) flag = FLAG_EDGE;
    else flag = FLAG_NORMAL;
    if (mid != 0) begin
      offset = longint'(mid) - longint'(c.center_index);
      mag = (offset > 0) ? offset : -offset;
      powered = 1;
      for (int k = 0; k < c.error_power; k++) begin
        powered = powered * mag;
        if (powered > POWER_CEIL) powered = POWER_CEIL;
      end
      scaled = (longint'(c.gain_kp) * powered) / GAIN_SCALE;
      if (scaled > CORR_LIMIT) scaled = CORR_LIMIT;
      // zero offset takes the negative side
      r.correction = (offset > 0) ? 9'(scaled) : 9'(-scaled);
      r.line_flag = flag;
      r.tracked_center = 4'(mid);
    end else begin
      r.correction = '0;
      r.line_flag = FLAG_NONE;
      r.tracked_center = c.center_index;
    end
    return r;
  endfunction

  function automatic logic [15:0] band(int lo, int hi);
    logic [15:0] f;
    f = '0;
    for (int i = 0; i < SENSOR_COUNT; i++)
      if (i >= lo && i <= hi) f[i] = 1'b1;
    return f;
  endfunction

  // Mostly a drifting line so the frame-to-frame mask keeps a run alive.
  function automatic logic [15:0] next_frame();
    int kind, a, b, w;
    logic [15:0] f;
    if (repeat_next) begin
      repeat_next = 1'b0;
      return gen_last;
    end
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      track_pos = track_pos + int'($urandom_range(0, 2)) - 1;
      if (track_pos < -2) track_pos = -2;
      if (track_pos > SENSOR_COUNT + 1) track_pos = SENSOR_COUNT + 1;
      if ($urandom_range(0, 7) == 0) track_w = $urandom_range(1, 14);
      a = track_pos - track_w / 2;
      f = band(a, a + track_w - 1);
      if ($urandom_range(0, 3) == 0) f[$urandom_range(0, 15)] ^= 1'b1;
    end else if (kind < 70) begin
      // two runs, repeated next frame so equal widths survive the mask
      w = $urandom_range(0, 5);
      a = $urandom_range(0, 7);
      b = a + w + 2 + $urandom_range(0, 5);
      f = band(a, a + w) | band(b, b + w);
      repeat_next = 1'b1;
    end else if (kind < 85) begin
      f = 16'($urandom);
    end else if (kind < 90) begin
      f = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      f = gen_last;
    end
    gen_last = f;
    return f;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(predict_steering(sensor_bits, last_frame, active_cfg));
        last_frame = sensor_bits;
        frames_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          sensor_bits <= frames_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: switches between stall patterns, with one long hold
  int rx_tick = 0;
  int rx_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 160 == 0) rx_mode = $urandom_range(0, 3);
      if (!hold_done && results_checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_tick % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected item: correction %0d flag %0d center %0d",
                 $time, correction, line_flag, tracked_center);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (correction !== want.correction) begin
          $display("%0t: correction expected %0d actual %0d",
                   $time, want.correction, correction);
          mismatches++;
        end
        if (line_flag !== want.line_flag) begin
          $display("%0t: line_flag expected %0d actual %0d",
                   $time, want.line_flag, line_flag);
          mismatches++;
        end
        if (tracked_center !== want.tracked_center) begin
          $display("%0t: tracked_center expected %0d actual %0d",
                   $time, want.tracked_center, tracked_center);
          mismatches++;
        end
        results_checked++;
        flag_seen[want.line_flag]++;
        if (want.correction == CORR_LIMIT || want.correction == -CORR_LIMIT) saturated++;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_KP:   active_cfg.gain_kp = value[15:0];
      REG_ERR_POWER: active_cfg.error_power = value[2:0];
      REG_CENTER:    active_cfg.center_index = value[3:0];
      REG_WHITE_W:   active_cfg.all_white_width = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] gain, input logic [2:0] pw,
                                input logic [3:0] ctr, input logic [3:0] ww);
    write_reg(REG_GAIN_KP, 32'(gain));
    write_reg(REG_ERR_POWER, 32'(pw));
    write_reg(REG_CENTER, 32'(ctr));
    write_reg(REG_WHITE_W, 32'(ww));
    settings_used++;
  endtask

  // sender holds off until every predicted result is back, then the block settles
  task automatic wait_idle();
    do @(posedge clk);
    while (frames_to_send.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first frame is masked by the cleared history
    frames_to_send.push_back(16'hFFFF);
    frames_to_send.push_back(16'hFFFF);   // full bar, all white
    frames_to_send.push_back(16'h0000);
    frames_to_send.push_back(16'h0001);
    frames_to_send.push_back(16'h0001);   // real run with midpoint zero
    frames_to_send.push_back(16'h8000);
    frames_to_send.push_back(16'h8000);   // top end
    frames_to_send.push_back(16'h0F0F);
    frames_to_send.push_back(16'h0F0F);   // tie, later run wins
    frames_to_send.push_back(16'h5555);
    frames_to_send.push_back(16'h5555);   // single sensors, width zero
    frames_to_send.push_back(16'h0100);
    frames_to_send.push_back(16'h0100);   // zero offset
    frames_to_send.push_back(16'h7FFE);
    frames_to_send.push_back(16'h7FFE);
    wait_idle();

    // zero offset with power zero gives minus the gain, saturated
    apply_settings(16'hFFFF, 3'd0, 4'd8, 4'd0);
    frames_to_send.push_back(16'h0100);
    frames_to_send.push_back(16'h0100);
    wait_idle();
    apply_settings(16'd250, 3'd0, 4'd8, 4'd15);
    frames_to_send.push_back(16'h0100);
    wait_idle();
    // largest power and gain
    apply_settings(16'hFFFF, 3'd7, 4'd0, 4'd15);
    frames_to_send.push_back(16'h8000);
    frames_to_send.push_back(16'h8000);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_settings(16'd100, 3'd1, 4'd8, 4'd10);
        1: apply_settings(16'hFFFF, 3'd7, 4'd15, 4'd15);
        2: apply_settings(16'd0, 3'd0, 4'd0, 4'd0);
        3: apply_settings(16'd150, 3'd2, 4'd4, 4'd6);
        default:
          apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                           16'($urandom_range(0, 600)),
                         3'($urandom_range(0, 7)), 4'($urandom), 4'($urandom));
      endcase
      repeat (PHASE_FRAMES) frames_to_send.push_back(next_frame());
      wait_idle();
    end

    $display("Ran %0d frames under %0d register settings, %0d results checked.",
             frames_sent, settings_used, results_checked);
    $display("Flags normal/none/end/white: %0d/%0d/%0d/%0d, saturated corrections: %0d",
             flag_seen[0], flag_seen[1], flag_seen[2], flag_seen[3], saturated);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending.", predicted_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
